>>> rtl/dlct_pkg.sv
// Shared types, widths and codes of the delta-list callout timer.
package dlct_pkg;

  localparam int CMD_W      = 2;
  localparam int HANDLER_W  = 16;
  localparam int ARG_W      = 32;
  localparam int DELAY_W    = 24;
  localparam int STATUS_W   = 3;
  localparam int LATE_W     = 25;
  localparam int DELTA_W    = 32;
  localparam int PAY_W      = HANDLER_W + ARG_W;
  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_PAD_W  = OUT_TDATA_W - LATE_W - ARG_W - HANDLER_W;

  // Most expired entries popped by one drain.
  localparam int RESULT_CAP = 32;
  localparam int KW         = $clog2(RESULT_CAP + 1);

  localparam logic signed [DELTA_W-1:0] DELTA_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = 32'sh8000_0000;
  localparam logic signed [DELTA_W-1:0] LATE_MIN  = -32'sd16777215;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_DRAIN  = 2'd1,
    CMD_SCHED  = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE     = 3'd0,
    STAT_EXPIRED  = 3'd1,
    STAT_NOTHING  = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_RD,
    ST_T_EV,
    ST_S_FRD,
    ST_S_FEV,
    ST_S_WRD,
    ST_S_WEV,
    ST_S_INS1,
    ST_S_INS2,
    ST_C_RD,
    ST_C_EV,
    ST_C_HIT,
    ST_C_FIX,
    ST_D_RD,
    ST_D_EV,
    ST_D_LAST,
    ST_FIN
  } state_e;

endpackage

>>> rtl/delta_list_callout_timer.sv
// Delta-list callout timer queue: linked entries in RAM walked by a small sequencer.
// Each visited list entry is read and then evaluated; a schedule into a full table goes
// straight to its status result. The next command is taken in the cycle after the last
// result is loaded, and a stalled result holds the sequencer. One command at a time.
// Reset (rst_ni low, async) empties the queue, chains every entry as free, drops results.
module delta_list_callout_timer #(
  parameter int ENTRIES = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command side
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] handler_id, [47:16] callout_arg, [71:48] delay_ticks
  input  logic [dlct_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] cmd
  input  logic [dlct_pkg::CMD_W-1:0]          s_axis_tuser,
  // Result side
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] expired_handler, [47:16] expired_arg, [72:48] lateness, [79:73] zero
  output logic [dlct_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [2:0] status
  output logic [dlct_pkg::STATUS_W-1:0]       m_axis_tuser,
  output logic                                m_axis_tlast
);
  import dlct_pkg::*;

  // Entry index widths: IX addresses the RAMs, IW also holds the null marker.
  localparam int IX = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IW = $clog2(ENTRIES + 1);
  // Remaining time during a schedule walk can grow past 32 bits when it
  // passes overdue (negative) entries, hence the extra headroom.
  localparam int TW = DELTA_W + 2 + $clog2(ENTRIES);
  localparam logic [IW-1:0] NIL = IW'(ENTRIES);
  localparam logic [IW-1:0] ENTRIES_CNT = IW'(ENTRIES);

  // Sequencer state
  state_e              state_q, state_d;
  status_e             fin_st_q, fin_st_d;
  logic [IW-1:0]       qhead_q, qhead_d;
  logic [IW-1:0]       fhead_q, fhead_d;
  logic [IW-1:0]       cur_q, cur_d;
  logic [IW-1:0]       prev_q, prev_d;
  logic [IW-1:0]       nw_q, nw_d;
  logic [IW-1:0]       cnt_q, cnt_d;
  logic [KW-1:0]       k_q, k_d;
  logic [ENTRIES-1:0]  lvld_q;

  // Command operands
  logic [HANDLER_W-1:0]       h_q, h_d;
  logic [ARG_W-1:0]           a_q, a_d;
  logic signed [TW-1:0]       t_q, t_d;
  logic signed [DELTA_W-1:0]  curd_q, curd_d;
  logic signed [DELTA_W-1:0]  newd_q, newd_d;

  // Expired entry held back until we know whether another follows
  logic                 pend_v_q, pend_v_d;
  logic [HANDLER_W-1:0] pend_h_q, pend_h_d;
  logic [ARG_W-1:0]     pend_a_q, pend_a_d;
  logic [LATE_W-1:0]    pend_late_q, pend_late_d;

  // Output register
  logic                 ov_q;
  logic [STATUS_W-1:0]  o_st_q;
  logic [HANDLER_W-1:0] o_h_q;
  logic [ARG_W-1:0]     o_a_q;
  logic [LATE_W-1:0]    o_late_q;
  logic                 o_last_q;
  logic                 out_free;
  logic                 emit_v;
  status_e              emit_st;
  logic [HANDLER_W-1:0] emit_h;
  logic [ARG_W-1:0]     emit_a;
  logic [LATE_W-1:0]    emit_late;
  logic                 emit_last;

  // RAM ports
  logic [IX-1:0]        rd_addr;
  logic [IX-1:0]        raddr_q;
  logic                 dwe, lwe, pwe;
  logic [IX-1:0]        dwaddr, lwaddr, pwaddr;
  logic [DELTA_W-1:0]   dwdata;
  logic [IW-1:0]        lwdata;
  logic [PAY_W-1:0]     pwdata;
  logic [DELTA_W-1:0]   d_rdata;
  logic [IW-1:0]        l_rdata;
  logic [PAY_W-1:0]     p_rdata;

  // Shared arithmetic unit
  logic signed [TW-1:0]      alu_a, alu_b, alu_sum;
  logic                      alu_sub;
  logic signed [DELTA_W-1:0] alu_sat;

  logic signed [TW-1:0] d_ext, curd_ext, newd_ext, late_min_ext;
  logic [IW-1:0]        link_raw, nx;
  logic                 d_le0, t_gt;
  cmd_e                 in_cmd;

  dlct_ram #(.WIDTH(DELTA_W), .DEPTH(ENTRIES)) u_delta_ram (
    .clk_i   (clk_i),
    .we_i    (dwe),
    .waddr_i (dwaddr),
    .wdata_i (dwdata),
    .raddr_i (rd_addr),
    .rdata_o (d_rdata)
  );

  dlct_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lwe),
    .waddr_i (lwaddr),
    .wdata_i (lwdata),
    .raddr_i (rd_addr),
    .rdata_o (l_rdata)
  );

  dlct_ram #(.WIDTH(PAY_W), .DEPTH(ENTRIES)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pwe),
    .waddr_i (pwaddr),
    .wdata_i (pwdata),
    .raddr_i (rd_addr),
    .rdata_o (p_rdata)
  );

  dlct_alu #(.TW(TW)) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .sat_o (alu_sat)
  );

  // Every walk reads the entry under cur_q; data shows up in the next cycle.
  assign rd_addr = cur_q[IX-1:0];

  assign d_ext        = {{(TW-DELTA_W){d_rdata[DELTA_W-1]}}, d_rdata};
  assign curd_ext     = {{(TW-DELTA_W){curd_q[DELTA_W-1]}}, curd_q};
  assign newd_ext     = {{(TW-DELTA_W){newd_q[DELTA_W-1]}}, newd_q};
  assign late_min_ext = {{(TW-DELTA_W){LATE_MIN[DELTA_W-1]}}, LATE_MIN};

  // A link never written still holds its reset value: the free chain i -> i+1.
  assign link_raw = lvld_q[raddr_q] ? l_rdata : (IW'(raddr_q) + IW'(1));
  assign nx       = (link_raw >= NIL) ? NIL : link_raw;

  assign d_le0  = d_rdata[DELTA_W-1] || (d_rdata == '0);
  // During the schedule walk the unit computes t - delta: positive means delta < t.
  assign t_gt   = !alu_sum[TW-1] && (alu_sum != '0);
  assign in_cmd = cmd_e'(s_axis_tuser);

  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Sequencer: next state, list updates, operand selection and result load.
  always_comb begin
    state_d     = state_q;
    fin_st_d    = fin_st_q;
    qhead_d     = qhead_q;
    fhead_d     = fhead_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    nw_d        = nw_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    h_d         = h_q;
    a_d         = a_q;
    t_d         = t_q;
    curd_d      = curd_q;
    newd_d      = newd_q;
    pend_v_d    = pend_v_q;
    pend_h_d    = pend_h_q;
    pend_a_d    = pend_a_q;
    pend_late_d = pend_late_q;

    dwe    = 1'b0;
    dwaddr = cur_q[IX-1:0];
    dwdata = alu_sat;
    lwe    = 1'b0;
    lwaddr = cur_q[IX-1:0];
    lwdata = fhead_q;
    pwe    = 1'b0;
    pwaddr = cur_q[IX-1:0];
    pwdata = {a_q, h_q};

    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;

    emit_v    = 1'b0;
    emit_st   = fin_st_q;
    emit_h    = '0;
    emit_a    = '0;
    emit_late = '0;
    emit_last = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          h_d    = s_axis_tdata[HANDLER_W-1:0];
          a_d    = s_axis_tdata[HANDLER_W+ARG_W-1:HANDLER_W];
          t_d    = {{(TW-DELAY_W){1'b0}},
                    s_axis_tdata[HANDLER_W+ARG_W+DELAY_W-1:HANDLER_W+ARG_W]};
          cnt_d  = '0;
          k_d    = '0;
          prev_d = NIL;
          cur_d  = qhead_q;
          unique case (in_cmd)
            CMD_TICK: begin
              fin_st_d = STAT_DONE;
              state_d  = (qhead_q == NIL) ? ST_FIN : ST_T_RD;
            end
            CMD_DRAIN: begin
              fin_st_d = STAT_NOTHING;
              state_d  = (qhead_q == NIL) ? ST_FIN : ST_D_RD;
            end
            CMD_SCHED: begin
              cur_d = fhead_q;
              if (fhead_q == NIL) begin
                fin_st_d = STAT_FULL;
                state_d  = ST_FIN;
              end else begin
                fin_st_d = STAT_DONE;
                state_d  = ST_S_FRD;
              end
            end
            CMD_CANCEL: begin
              fin_st_d = STAT_NOTFOUND;
              state_d  = (qhead_q == NIL) ? ST_FIN : ST_C_RD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      // Tick: decrement overdue head entries and the first pending one.
      ST_T_RD: state_d = ST_T_EV;
      ST_T_EV: begin
        alu_a   = d_ext;
        alu_b   = TW'(1);
        alu_sub = 1'b1;
        dwe     = 1'b1;
        if (d_le0 && (cnt_q < ENTRIES_CNT)) begin
          cnt_d = cnt_q + IW'(1);
          if (nx == NIL) begin
            state_d = ST_FIN;
          end else begin
            cur_d   = nx;
            state_d = ST_T_RD;
          end
        end else begin
          state_d = ST_FIN;
        end
      end

      // Schedule: take the free head, then walk to the insertion point.
      ST_S_FRD: state_d = ST_S_FEV;
      ST_S_FEV: begin
        nw_d    = cur_q;
        fhead_d = nx;
        pwe     = 1'b1;
        cur_d   = qhead_q;
        state_d = (qhead_q == NIL) ? ST_S_INS1 : ST_S_WRD;
      end
      ST_S_WRD: state_d = ST_S_WEV;
      ST_S_WEV: begin
        alu_a   = t_q;
        alu_b   = d_ext;
        alu_sub = 1'b1;
        curd_d  = d_rdata;
        if (t_gt && (cnt_q < ENTRIES_CNT)) begin
          t_d     = alu_sum;
          prev_d  = cur_q;
          cnt_d   = cnt_q + IW'(1);
          cur_d   = nx;
          state_d = (nx == NIL) ? ST_S_INS1 : ST_S_WRD;
        end else begin
          state_d = ST_S_INS1;
        end
      end
      ST_S_INS1: begin
        // New entry links to the insertion point and takes the clamped remainder.
        alu_a  = t_q;
        lwe    = 1'b1;
        lwaddr = nw_q[IX-1:0];
        lwdata = cur_q;
        dwe    = 1'b1;
        dwaddr = nw_q[IX-1:0];
        newd_d = alu_sat;
        if (prev_q == NIL) begin
          qhead_d = nw_q;
        end
        state_d = ST_S_INS2;
      end
      ST_S_INS2: begin
        // Predecessor points at the new entry; successor gives up its share.
        alu_a   = curd_ext;
        alu_b   = newd_ext;
        alu_sub = 1'b1;
        if (prev_q != NIL) begin
          lwe    = 1'b1;
          lwaddr = prev_q[IX-1:0];
          lwdata = nw_q;
        end
        dwe     = (cur_q != NIL);
        state_d = ST_FIN;
      end

      // Cancel: search for the first matching handler and argument.
      ST_C_RD: state_d = ST_C_EV;
      ST_C_EV: begin
        if (cnt_q >= ENTRIES_CNT) begin
          state_d = ST_FIN;
        end else if (p_rdata == {a_q, h_q}) begin
          fin_st_d = STAT_DONE;
          nw_d     = cur_q;
          curd_d   = d_rdata;
          cur_d    = nx;
          state_d  = ST_C_HIT;
        end else begin
          prev_d = cur_q;
          cnt_d  = cnt_q + IW'(1);
          if (nx == NIL) begin
            state_d = ST_FIN;
          end else begin
            cur_d   = nx;
            state_d = ST_C_RD;
          end
        end
      end
      ST_C_HIT: begin
        // Return the victim to the free list while the successor is read.
        lwe     = 1'b1;
        lwaddr  = nw_q[IX-1:0];
        lwdata  = fhead_q;
        fhead_d = nw_q;
        if (prev_q == NIL) begin
          qhead_d = cur_q;
        end
        state_d = ST_C_FIX;
      end
      ST_C_FIX: begin
        alu_a = d_ext;
        alu_b = curd_ext;
        if (prev_q != NIL) begin
          lwe    = 1'b1;
          lwaddr = prev_q[IX-1:0];
          lwdata = cur_q;
        end
        // Pass a positive remaining delay on to the successor.
        dwe     = (cur_q != NIL) && !curd_q[DELTA_W-1] && (curd_q != '0);
        state_d = ST_FIN;
      end

      // Drain: pop due head entries, one result behind the pop.
      ST_D_RD: state_d = ST_D_EV;
      ST_D_EV: begin
        alu_a   = d_ext;
        alu_b   = late_min_ext;
        alu_sub = 1'b1;
        emit_st   = STAT_EXPIRED;
        emit_h    = pend_h_q;
        emit_a    = pend_a_q;
        emit_late = pend_late_q;
        emit_last = 1'b0;
        if (d_le0) begin
          if (!pend_v_q || out_free) begin
            emit_v      = pend_v_q;
            qhead_d     = nx;
            lwe         = 1'b1;
            fhead_d     = cur_q;
            pend_v_d    = 1'b1;
            pend_h_d    = p_rdata[HANDLER_W-1:0];
            pend_a_d    = p_rdata[PAY_W-1:HANDLER_W];
            pend_late_d = alu_sum[TW-1] ? LATE_MIN[LATE_W-1:0] : d_rdata[LATE_W-1:0];
            k_d         = k_q + KW'(1);
            if ((nx == NIL) || ((k_q + KW'(1)) == KW'(RESULT_CAP))) begin
              state_d = ST_D_LAST;
            end else begin
              cur_d   = nx;
              state_d = ST_D_RD;
            end
          end
        end else begin
          state_d = pend_v_q ? ST_D_LAST : ST_FIN;
        end
      end
      ST_D_LAST: begin
        emit_st   = STAT_EXPIRED;
        emit_h    = pend_h_q;
        emit_a    = pend_a_q;
        emit_late = pend_late_q;
        if (out_free) begin
          emit_v   = 1'b1;
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      // Single closing result carrying only a status.
      ST_FIN: begin
        if (out_free) begin
          emit_v  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      qhead_q  <= NIL;
      fhead_q  <= '0;
      lvld_q   <= '0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      qhead_q  <= qhead_d;
      fhead_q  <= fhead_d;
      pend_v_q <= pend_v_d;
      if (lwe) begin
        lvld_q[lwaddr] <= 1'b1;
      end
      if (emit_v) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Working registers: no reset needed, every command loads what it uses.
  always_ff @(posedge clk_i) begin
    fin_st_q    <= fin_st_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    nw_q        <= nw_d;
    cnt_q       <= cnt_d;
    k_q         <= k_d;
    h_q         <= h_d;
    a_q         <= a_d;
    t_q         <= t_d;
    curd_q      <= curd_d;
    newd_q      <= newd_d;
    pend_h_q    <= pend_h_d;
    pend_a_q    <= pend_a_d;
    pend_late_q <= pend_late_d;
    raddr_q     <= rd_addr;
    if (emit_v) begin
      o_st_q   <= emit_st;
      o_h_q    <= emit_h;
      o_a_q    <= emit_a;
      o_late_q <= emit_late;
      o_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, o_late_q, o_a_q, o_h_q};
  assign m_axis_tuser  = o_st_q;
  assign m_axis_tlast  = o_last_q;

  // The pending list and the free list never share a head entry.
  a_heads_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qhead_q != NIL) |-> (qhead_q != fhead_q))
    else $error("queue head and free head coincide");

  // Head pointers stay within the table or at null.
  a_heads_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qhead_q <= NIL) && (fhead_q <= NIL))
    else $error("head pointer out of range");

  // A held-back expired entry exists only while a drain runs.
  a_pend_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> ((state_q == ST_D_RD) || (state_q == ST_D_EV) || (state_q == ST_D_LAST)))
    else $error("pending expired entry outside drain");

  // An accepted command always starts the sequencer.
  a_cmd_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != ST_IDLE))
    else $error("accepted command did not start work");

endmodule

>>> rtl/dlct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dlct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dlct_alu.sv
// Shared wide adder/subtractor with saturation to the signed delta range.
module dlct_alu #(
  parameter int TW = 40
) (
  input  logic signed [TW-1:0]               a_i,
  input  logic signed [TW-1:0]               b_i,
  input  logic                               sub_i,
  output logic signed [TW-1:0]               sum_o,
  output logic signed [dlct_pkg::DELTA_W-1:0] sat_o
);
  import dlct_pkg::*;

  logic [TW-DELTA_W:0] upper;

  assign sum_o = sub_i ? (a_i - b_i) : (a_i + b_i);
  assign upper = sum_o[TW-1:DELTA_W-1];

  // Clamp to the signed delta bounds when the upper bits disagree.
  always_comb begin
    if ((&upper) || (~|upper)) begin
      sat_o = sum_o[DELTA_W-1:0];
    end else if (sum_o[TW-1]) begin
      sat_o = DELTA_MIN;
    end else begin
      sat_o = DELTA_MAX;
    end
  end

endmodule

>>> tb/sv/delta_list_callout_timer_chk.sv
`timescale 1ns / 100ps
// Scoreboard for the delta-list callout timer: mirrors the queue and checks every result.
module delta_list_callout_timer_chk #(
  parameter int ENTRIES = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [dlct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [dlct_pkg::CMD_W-1:0]       s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [dlct_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [dlct_pkg::STATUS_W-1:0]    m_axis_tuser,
  input  logic                             m_axis_tlast,
  output int                               fail_count_o,
  output int                               owed_count_o
);
  import dlct_pkg::*;

  localparam int NIL = ENTRIES;

  typedef struct packed {
    status_e                    st;
    logic [HANDLER_W-1:0]       hnd;
    logic [ARG_W-1:0]           arg;
    logic signed [LATE_W-1:0]   late;
    logic                       last;
  } callout_result_t;

  // Mirror of the timer table.
  logic signed [DELTA_W-1:0] slot_delta [ENTRIES];
  logic [HANDLER_W-1:0]      slot_hnd   [ENTRIES];
  logic [ARG_W-1:0]          slot_arg   [ENTRIES];
  int                        slot_next  [ENTRIES];
  int                        busy_head;
  int                        idle_head;

  callout_result_t results_owed[$];
  int              mismatches = 0;
  int              results_seen = 0;

  assign fail_count_o = mismatches;

  function automatic logic signed [DELTA_W-1:0] clamp_delta(longint v);
    if (v > longint'(DELTA_MAX)) return DELTA_MAX;
    if (v < longint'(DELTA_MIN)) return DELTA_MIN;
    return v[DELTA_W-1:0];
  endfunction

  function automatic int link_after(int i);
    if (i < 0 || i >= ENTRIES) return NIL;
    return (slot_next[i] >= ENTRIES) ? NIL : slot_next[i];
  endfunction

  function automatic void owe(status_e st, logic [HANDLER_W-1:0] h, logic [ARG_W-1:0] a,
                              logic signed [LATE_W-1:0] late, logic last);
    results_owed.push_back('{st, h, a, late, last});
  endfunction

  // Decrement every overdue head entry and the first one still pending.
  function automatic void count_down();
    int p;
    int n;
    p = busy_head;
    n = 0;
    while (p < ENTRIES && slot_delta[p] <= 0 && n < ENTRIES) begin
      slot_delta[p] = clamp_delta(longint'(slot_delta[p]) - 1);
      p = link_after(p);
      n++;
    end
    if (p < ENTRIES) slot_delta[p] = clamp_delta(longint'(slot_delta[p]) - 1);
  endfunction

  function automatic status_e enqueue_callout(logic [HANDLER_W-1:0] h, logic [ARG_W-1:0] a,
                                              longint t);
    int nw;
    int prev;
    int cur;
    int n;
    nw = idle_head;
    if (nw >= ENTRIES) return STAT_FULL;
    idle_head = link_after(nw);
    slot_hnd[nw] = h;
    slot_arg[nw] = a;
    prev = NIL;
    cur = busy_head;
    n = 0;
    // Skip every entry strictly earlier than the remaining time.
    while (cur < ENTRIES && longint'(slot_delta[cur]) < t && n < ENTRIES) begin
      t -= longint'(slot_delta[cur]);
      prev = cur;
      cur = link_after(cur);
      n++;
    end
    if (prev == NIL) busy_head = nw;
    else slot_next[prev] = nw;
    slot_next[nw] = cur;
    slot_delta[nw] = clamp_delta(t);
    if (cur < ENTRIES)
      slot_delta[cur] = clamp_delta(longint'(slot_delta[cur]) - longint'(slot_delta[nw]));
    return STAT_DONE;
  endfunction

  function automatic status_e cancel_callout(logic [HANDLER_W-1:0] h, logic [ARG_W-1:0] a);
    int prev;
    int cur;
    int nx;
    int n;
    prev = NIL;
    cur = busy_head;
    n = 0;
    while (cur < ENTRIES && n < ENTRIES) begin
      nx = link_after(cur);
      if (slot_hnd[cur] == h && slot_arg[cur] == a) begin
        // Hand a positive remainder on to the successor.
        if (nx < ENTRIES && slot_delta[cur] > 0)
          slot_delta[nx] = clamp_delta(longint'(slot_delta[nx]) + longint'(slot_delta[cur]));
        if (prev == NIL) busy_head = nx;
        else slot_next[prev] = nx;
        slot_next[cur] = idle_head;
        idle_head = cur;
        return STAT_DONE;
      end
      prev = cur;
      cur = nx;
      n++;
    end
    return STAT_NOTFOUND;
  endfunction

  function automatic void drain_expired();
    int k;
    int p;
    logic signed [DELTA_W-1:0] late;
    k = 0;
    while (k < RESULT_CAP && busy_head < ENTRIES && slot_delta[busy_head] <= 0) begin
      p = busy_head;
      late = slot_delta[p];
      if (late < LATE_MIN) late = LATE_MIN;
      busy_head = link_after(p);
      slot_next[p] = idle_head;
      idle_head = p;
      owe(STAT_EXPIRED, slot_hnd[p], slot_arg[p], late[LATE_W-1:0], 1'b0);
      k++;
    end
    if (k == 0) owe(STAT_NOTHING, '0, '0, '0, 1'b1);
    else results_owed[results_owed.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    callout_result_t           want;
    logic [HANDLER_W-1:0]      got_hnd;
    logic [ARG_W-1:0]          got_arg;
    logic signed [LATE_W-1:0]  got_late;
    logic [OUT_PAD_W-1:0]      got_pad;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_delta[i] = '0;
        slot_hnd[i]   = '0;
        slot_arg[i]   = '0;
        slot_next[i]  = i + 1;
      end
      busy_head = NIL;
      idle_head = 0;
      results_owed.delete();
    end else begin
      // Predict first: a result never leaves in the cycle its command enters.
      if (s_axis_tvalid && s_axis_tready) begin
        case (cmd_e'(s_axis_tuser))
          CMD_TICK: begin
            count_down();
            owe(STAT_DONE, '0, '0, '0, 1'b1);
          end
          CMD_SCHED: owe(enqueue_callout(s_axis_tdata[15:0], s_axis_tdata[47:16],
                                         longint'(s_axis_tdata[71:48])), '0, '0, '0, 1'b1);
          CMD_CANCEL: owe(cancel_callout(s_axis_tdata[15:0], s_axis_tdata[47:16]),
                          '0, '0, '0, 1'b1);
          default: drain_expired();
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_hnd  = m_axis_tdata[15:0];
        got_arg  = m_axis_tdata[47:16];
        got_late = m_axis_tdata[72:48];
        got_pad  = m_axis_tdata[79:73];
        results_seen++;
        if (results_owed.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d arrived unexpected: status=%0d hnd=%h arg=%h late=%0d",
                     results_seen, m_axis_tuser, got_hnd, got_arg, got_late);
        end else begin
          want = results_owed.pop_front();
          if (m_axis_tuser !== want.st || got_hnd !== want.hnd || got_arg !== want.arg ||
              got_late !== want.late || m_axis_tlast !== want.last || got_pad !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR: result %0d expected st=%0d hnd=%h arg=%h late=%0d last=%b,",
                        " got st=%0d hnd=%h arg=%h late=%0d last=%b pad=%h"},
                       results_seen, want.st, want.hnd, want.arg, want.late, want.last,
                       m_axis_tuser, got_hnd, got_arg, got_late, m_axis_tlast, got_pad);
          end
        end
      end
    end
    owed_count_o = results_owed.size();
  end

endmodule

>>> tb/sv/delta_list_callout_timer_tb.sv
`timescale 1ns / 100ps
// Top-level testbench of the delta-list callout timer: clock, reset, stimulus and verdict.
module delta_list_callout_timer_tb;
  import dlct_pkg::*;

  localparam int ENTRIES     = 32;
  localparam int TOTAL_ITEMS = 310;
  // Longest single command walks the whole table.
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 24;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [15:0] handler_id, [47:16] callout_arg, [71:48] delay_ticks
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // [1:0] cmd
  logic [CMD_W-1:0]       s_axis_tuser = CMD_TICK;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [15:0] expired_handler, [47:16] expired_arg, [72:48] lateness, [79:73] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // [2:0] status
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   m_axis_tlast;

  int fail_count;
  int owed_count;

  // Idle shaping: sender gaps and receiver stalls are switched on per phase.
  int gap_mode   = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int issued     = 0;

  // Pairs handed to schedule, so that most cancels aim at something queued.
  typedef struct {
    logic [HANDLER_W-1:0] hnd;
    logic [ARG_W-1:0]     arg;
  } callout_pair_t;
  callout_pair_t armed_callouts[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  delta_list_callout_timer #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  delta_list_callout_timer_chk #(
    .ENTRIES(ENTRIES)
  ) chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .owed_count_o (owed_count)
  );

  // Result side: mostly ready; in stall phases drop ready for short bursts and,
  // now and then, for a long stretch.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_mode != 0 && $urandom_range(0, 99) < 30) begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                      : $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Few distinct handlers most of the time so that duplicate pairs and
  // near-miss cancels are common; full-range values keep every bit moving.
  function automatic logic [HANDLER_W-1:0] pick_handler();
    if ($urandom_range(0, 1) == 0) return HANDLER_W'($urandom_range(1, 4));
    return HANDLER_W'($urandom);
  endfunction

  function automatic logic [ARG_W-1:0] pick_arg();
    if ($urandom_range(0, 1) == 0) return ARG_W'($urandom_range(0, 3));
    return $urandom;
  endfunction

  // Short delays dominate so that entries actually come due under the ticks.
  function automatic logic [DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return DELAY_W'($urandom_range(0, 4));
    if (r < 80) return DELAY_W'($urandom_range(5, 40));
    if (r < 95) return DELAY_W'($urandom_range(41, 2000));
    if (r < 98) return DELAY_W'($urandom);
    return '1;
  endfunction

  // Present one command and hold it until the transaction completes, then
  // optionally idle. Valid stays high across back-to-back commands.
  task automatic issue(cmd_e cmd, logic [HANDLER_W-1:0] h, logic [ARG_W-1:0] a,
                       logic [DELAY_W-1:0] d);
    int gap;
    int r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {d, a, h};
    do @(posedge clk_i); while (!s_axis_tready);
    issued++;
    if (cmd == CMD_SCHED) begin
      armed_callouts.push_back('{h, a});
      if (armed_callouts.size() > 48) void'(armed_callouts.pop_front());
    end
    gap = 0;
    if (gap_mode != 0) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(8, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Cancel a known pair most of the time (it may already be gone), else noise.
  task automatic issue_cancel();
    int idx;
    callout_pair_t pair;
    if (armed_callouts.size() != 0 && $urandom_range(0, 3) != 0) begin
      idx  = $urandom_range(0, armed_callouts.size() - 1);
      pair = armed_callouts[idx];
      armed_callouts.delete(idx);
      issue(CMD_CANCEL, pair.hnd, pair.arg, DELAY_W'($urandom));
    end else begin
      issue(CMD_CANCEL, pick_handler(), pick_arg(), DELAY_W'($urandom));
    end
  endtask

  initial begin
    int r;
    int phase;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-queue behavior first.
    issue(CMD_DRAIN, '0, '0, '0);
    issue(CMD_TICK, '0, '0, '0);
    issue(CMD_CANCEL, 16'h1234, 32'h0000_0001, '0);
    // Extremes of every field, equal delays, and a duplicate pair.
    issue(CMD_SCHED, 16'h0000, 32'h0000_0000, 24'h00_0000);
    issue(CMD_SCHED, 16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
    issue(CMD_SCHED, 16'h0011, 32'h0000_000A, 24'd5);
    issue(CMD_SCHED, 16'h0011, 32'h0000_000B, 24'd5);
    issue(CMD_SCHED, 16'h0022, 32'h0000_000C, 24'd3);
    issue(CMD_SCHED, 16'h0011, 32'h0000_000A, 24'd9);
    // Handler matches but argument belongs to another entry: a miss.
    issue(CMD_CANCEL, 16'h0011, 32'h0000_000C, '0);
    // Hit with a positive delta that moves on to the successor.
    issue(CMD_CANCEL, 16'h0022, 32'h0000_000C, '0);
    // Duplicate pair: only the earlier one goes.
    issue(CMD_CANCEL, 16'h0011, 32'h0000_000A, '0);
    // Zero-delay entry comes out with no lateness.
    issue(CMD_DRAIN, '0, '0, '0);
    repeat (6) issue(CMD_TICK, '0, '0, '0);
    issue(CMD_DRAIN, '0, '0, '0);
    issue(CMD_SCHED, 16'h5555, 32'h5555_5555, 24'h55_5555);
    issue(CMD_SCHED, 16'hAAAA, 32'hAAAA_AAAA, 24'hAA_AAAA);
    // Overdue head keeps counting down, so lateness goes negative.
    issue(CMD_SCHED, 16'h0077, 32'h0000_0077, 24'd0);
    repeat (3) issue(CMD_TICK, '0, '0, '0);
    issue(CMD_DRAIN, '0, '0, '0);

    // Random phases; every fourth one fills the table past capacity with
    // near-due entries and flushes it, which covers the full status and the
    // largest drain.
    phase = 0;
    while (issued < TOTAL_ITEMS) begin
      gap_mode   = ($urandom_range(0, 2) != 0) ? 1 : 0;
      stall_mode <= ($urandom_range(0, 2) != 0) ? 1 : 0;
      if (phase % 4 == 3) begin
        repeat (ENTRIES + 2)
          issue(CMD_SCHED, pick_handler(), pick_arg(), DELAY_W'($urandom_range(0, 2)));
        repeat (3) issue(CMD_TICK, '0, '0, '0);
        repeat (2) issue(CMD_DRAIN, '0, '0, '0);
        if ($urandom_range(0, 1) == 0) issue_cancel();
      end else begin
        repeat (30) begin
          r = $urandom_range(0, 99);
          if (r < 35) issue(CMD_SCHED, pick_handler(), pick_arg(), pick_delay());
          else if (r < 60) issue(CMD_TICK, pick_handler(), pick_arg(), DELAY_W'($urandom));
          else if (r < 78) issue(CMD_DRAIN, pick_handler(), pick_arg(), DELAY_W'($urandom));
          else issue_cancel();
        end
      end
      phase++;
    end

    // Release the bus and let every owed result come back.
    s_axis_tvalid <= 1'b0;
    stall_mode    <= 0;
    do @(negedge clk_i); while (owed_count != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && owed_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/dlct_pkg.sv
rtl/dlct_ram.sv
rtl/dlct_alu.sv
rtl/delta_list_callout_timer.sv
tb/sv/delta_list_callout_timer_chk.sv
tb/sv/delta_list_callout_timer_tb.sv
